// File: sv/ratalu_pkg.sv
package ratalu_pkg;

   localparam int WIDTH   = 32;
   localparam int FIELD_W = 32;
   localparam int KIND_W  = 4;
   localparam int CNT_W   = $clog2(WIDTH);

   typedef struct packed {
      logic             start;
      logic             div;
      logic [WIDTH-1:0] opa;
      logic [WIDTH-1:0] opb;
   } unit_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [2*WIDTH-1:0] prod;
   } unit_stat_type;

endpackage

// File: sv/ratalu_muldiv.sv
module ratalu_muldiv (
   input  logic                      clock,
   input  logic                      reset,
   input  ratalu_pkg::unit_cmd_type  cmd,
   output ratalu_pkg::unit_stat_type stat
);
   import ratalu_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic [WIDTH-1:0] mc_ff, mc_in;

   logic                    last;
   logic signed [WIDTH:0]   addend;
   logic signed [WIDTH:0]   mul_sum;
   logic        [WIDTH:0]   trial;
   logic        [WIDTH:0]   diff;
   logic                    ge;

   always_comb begin
      last   = (cnt_ff == CNT_W'(WIDTH - 1));
      addend = lo_ff[0] ? {mc_ff[WIDTH-1], mc_ff} : '0;
      // sign bit of the multiplier carries negative weight
      if (last) begin
         mul_sum = $signed({hi_ff[WIDTH-1], hi_ff}) - addend;
      end else begin
         mul_sum = $signed({hi_ff[WIDTH-1], hi_ff}) + addend;
      end
      trial = {hi_ff, lo_ff[WIDTH-1]};
      diff  = trial - {1'b0, mc_ff};
      ge    = (trial >= {1'b0, mc_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.div;
         cnt_in  = '0;
         hi_in   = '0;
         if (cmd.div) begin
            mc_in = cmd.opb;
            lo_in = cmd.opa;
         end else begin
            mc_in = cmd.opa;
            lo_in = cmd.opb;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (div_ff) begin
            // restoring step, quotient bits enter at the bottom
            hi_in = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            lo_in = {lo_ff[WIDTH-2:0], ge};
         end else begin
            hi_in = mul_sum[WIDTH:1];
            lo_in = {mul_sum[0], lo_ff[WIDTH-1:1]};
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mc_ff  <= mc_in;
   end

   assign stat = '{busy: busy_ff, done: done_ff, prod: {hi_ff, lo_ff}};

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("unit started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("unit done without a run");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && last && !cmd.start) |=> done_ff)
      else $error("last step did not finish");
`endif

endmodule

// File: sv/rational_number_alu_core.sv
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     kind, a_num, a_den, b_num, b_den
// rsp_      out        rsp_valid / rsp_stall     res_num, res_den, cmp_true, error
//
// one request at a time; the shared shift-add unit forms every product and quotient
// add, sub: three serial products before the response; mul, div, orderings: two serial products
// eq, unused kinds and make with a zero field go straight to the finish state without the unit
// make: binary gcd, then two serial divides, numerator first and denominator second
// reset is synchronous and clears the sequencer and the response valid
// a waiting response does not block the next request; only a second finished one waits
module rational_number_alu_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [ratalu_pkg::KIND_W-1:0]  req_kind,
   input  logic signed [ratalu_pkg::FIELD_W-1:0] req_a_num,
   input  logic signed [ratalu_pkg::FIELD_W-1:0] req_a_den,
   input  logic signed [ratalu_pkg::FIELD_W-1:0] req_b_num,
   input  logic signed [ratalu_pkg::FIELD_W-1:0] req_b_den,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ratalu_pkg::FIELD_W-1:0] rsp_res_num,
   output logic signed [ratalu_pkg::FIELD_W-1:0] rsp_res_den,
   output logic                                  rsp_cmp_true,
   output logic                                  rsp_error
);
   import ratalu_pkg::*;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 4'd0,
      KIND_SUB  = 4'd1,
      KIND_MUL  = 4'd2,
      KIND_DIV  = 4'd3,
      KIND_EQ   = 4'd4,
      KIND_LT   = 4'd5,
      KIND_LE   = 4'd6,
      KIND_GT   = 4'd7,
      KIND_GE   = 4'd8,
      KIND_MAKE = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_GCD,
      ST_DIV_N,
      ST_DIV_D,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic                      start_ff, start_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [WIDTH-1:0]   an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [2*WIDTH-1:0] x_ff, x_in;
   logic signed [WIDTH-1:0]   rn_ff, rn_in, rd_ff, rd_in;
   logic                      cmp_ff, cmp_in, err_ff, err_in;
   logic [WIDTH-1:0]          u_ff, u_in, v_ff, v_in, da_ff, da_in, dd_ff, dd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_W-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                      rsp_cmp_ff, rsp_cmp_in, rsp_err_ff, rsp_err_in;

   logic signed [WIDTH-1:0]   an_w, ad_w, bn_w, bd_w;
   logic [WIDTH-1:0]          an_mag, ad_mag;
   logic signed [2*WIDTH-1:0] prod_s;
   logic [WIDTH-1:0]          prod_lo;

   unit_cmd_type  cmd;
   unit_stat_type stat;

   ratalu_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_comb begin
      cmd.start = start_ff;
      cmd.div   = (state_ff == ST_DIV_N) || (state_ff == ST_DIV_D);
      unique case (state_ff)
         ST_MUL_X: begin
            cmd.opa = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
            cmd.opb = an_ff;
         end
         ST_MUL_Y: begin
            cmd.opa = ad_ff;
            cmd.opb = (kind_ff == KIND_MUL) ? bd_ff : bn_ff;
         end
         ST_MUL_Z: begin
            cmd.opa = ad_ff;
            cmd.opb = bd_ff;
         end
         ST_DIV_N: begin
            cmd.opa = da_ff;
            cmd.opb = u_ff;
         end
         ST_DIV_D: begin
            cmd.opa = dd_ff;
            cmd.opb = u_ff;
         end
         default: begin
            cmd.opa = '0;
            cmd.opb = '0;
         end
      endcase
   end

   always_comb begin
      an_w    = req_a_num[WIDTH-1:0];
      ad_w    = req_a_den[WIDTH-1:0];
      bn_w    = req_b_num[WIDTH-1:0];
      bd_w    = req_b_den[WIDTH-1:0];
      an_mag  = an_w[WIDTH-1] ? -an_w : an_w;
      ad_mag  = ad_w[WIDTH-1] ? -ad_w : ad_w;
      prod_s  = $signed(stat.prod);
      prod_lo = stat.prod[WIDTH-1:0];

      state_in = state_ff;
      start_in = 1'b0;
      kind_in  = kind_ff;
      an_in    = an_ff;
      ad_in    = ad_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      x_in     = x_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      cmp_in   = cmp_ff;
      err_in   = err_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      da_in    = da_ff;
      dd_in    = dd_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               an_in    = an_w;
               ad_in    = ad_w;
               bn_in    = bn_w;
               bd_in    = bd_w;
               rn_in    = '0;
               rd_in    = '0;
               cmp_in   = 1'b0;
               err_in   = 1'b0;
               state_in = ST_FINISH;
               unique case (req_kind)
                  KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV,
                  KIND_LT, KIND_LE, KIND_GT, KIND_GE: begin
                     state_in = ST_MUL_X;
                     start_in = 1'b1;
                  end
                  KIND_EQ: begin
                     cmp_in = (an_w == bn_w) && (ad_w == bd_w);
                  end
                  KIND_MAKE: begin
                     priority if (ad_w == '0) begin
                        err_in = 1'b1;
                     end else if (an_w == '0) begin
                        rd_in = ad_w[WIDTH-1] ? '1 : WIDTH'(1);
                     end else begin
                        u_in     = an_mag;
                        v_in     = ad_mag;
                        da_in    = an_mag;
                        dd_in    = ad_mag;
                        state_in = ST_GCD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL_X: begin
            if (stat.done) begin
               x_in     = prod_s;
               state_in = ST_MUL_Y;
               start_in = 1'b1;
            end
         end
         ST_MUL_Y: begin
            if (stat.done) begin
               state_in = ST_FINISH;
               unique case (kind_ff)
                  KIND_ADD: begin
                     rn_in    = x_ff[WIDTH-1:0] + prod_lo;
                     state_in = ST_MUL_Z;
                     start_in = 1'b1;
                  end
                  KIND_SUB: begin
                     rn_in    = x_ff[WIDTH-1:0] - prod_lo;
                     state_in = ST_MUL_Z;
                     start_in = 1'b1;
                  end
                  KIND_MUL, KIND_DIV: begin
                     rn_in  = x_ff[WIDTH-1:0];
                     rd_in  = prod_lo;
                     err_in = (prod_lo == '0);
                  end
                  KIND_LT: cmp_in = (x_ff <  prod_s);
                  KIND_LE: cmp_in = (x_ff <= prod_s);
                  KIND_GT: cmp_in = (x_ff >  prod_s);
                  KIND_GE: cmp_in = (x_ff >= prod_s);
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL_Z: begin
            if (stat.done) begin
               rd_in    = prod_lo;
               err_in   = (prod_lo == '0);
               state_in = ST_FINISH;
            end
         end
         ST_GCD: begin
            // binary gcd; common factors of two come off the dividends as well
            priority if (v_ff == '0) begin
               state_in = ST_DIV_N;
               start_in = 1'b1;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in  = u_ff >> 1;
               v_in  = v_ff >> 1;
               da_in = da_ff >> 1;
               dd_in = dd_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         ST_DIV_N: begin
            if (stat.done) begin
               rn_in    = an_ff[WIDTH-1] ? -prod_lo : prod_lo;
               state_in = ST_DIV_D;
               start_in = 1'b1;
            end
         end
         ST_DIV_D: begin
            if (stat.done) begin
               rd_in    = ad_ff[WIDTH-1] ? -prod_lo : prod_lo;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = FIELD_W'(rn_ff);
               rsp_den_in   = FIELD_W'(rd_ff);
               rsp_cmp_in   = cmp_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      x_ff       <= x_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      cmp_ff     <= cmp_in;
      err_ff     <= err_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      da_ff      <= da_in;
      dd_ff      <= dd_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_cmp_ff <= rsp_cmp_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = rsp_num_ff;
   assign rsp_res_den  = rsp_den_ff;
   assign rsp_cmp_true = rsp_cmp_ff;
   assign rsp_error    = rsp_err_ff;

`ifndef SYNTH
   a_cmp_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cmp_true) |->
         (rsp_res_num == '0) && (rsp_res_den == '0) && !rsp_error)
      else $error("comparison response carries a fraction or error");

   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == ST_MUL_X) || (state_ff == ST_MUL_Y) ||
                    (state_ff == ST_MUL_Z) || (state_ff == ST_DIV_N) ||
                    (state_ff == ST_DIV_D))
      else $error("unit finished while sequencer not waiting");

   a_start_stage: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == ST_MUL_X) || (state_ff == ST_MUL_Y) ||
                   (state_ff == ST_MUL_Z) || (state_ff == ST_DIV_N) ||
                   (state_ff == ST_DIV_D))
      else $error("unit start outside a unit stage");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (u_ff != '0))
      else $error("gcd operand reached zero");
`endif

endmodule
